// ===== rtl/core/kwm_pkg.sv =====
// shared types and constants of the k-way merge head row
package kwm_pkg;

  localparam int VALUE_W = 31;
  localparam int LIST_W = 3;
  localparam int NUM_LISTS_DEF = 6;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LIST_W-1:0]  list;
  } head_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic  load;
    logic  advance;
    head_t fresh;
  } cell_cmd_t;

endpackage

// ===== rtl/core/kwm_in_if.sv =====
// input channel: operation, list number and list element
interface kwm_in_if;
  import kwm_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [LIST_W-1:0]  list_index;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output operation, output list_index, output value,
                  input ready);
  modport sink (input valid, input operation, input list_index, input value,
                output ready);
endinterface

// ===== rtl/core/kwm_out_if.sv =====
// output channel: merged value and top-of-row status
interface kwm_out_if;
  import kwm_pkg::*;

  logic               valid;
  logic               ready;
  logic               emitted;
  logic [VALUE_W-1:0] emitted_value;
  logic [LIST_W-1:0]  emitted_list;
  logic [LIST_W-1:0]  next_list;
  logic               finished;

  modport source (output valid, output emitted, output emitted_value,
                  output emitted_list, output next_list, output finished,
                  input ready);
  modport sink (input valid, input emitted, input emitted_value,
                input emitted_list, input next_list, input finished,
                output ready);
endinterface

// ===== rtl/core/kwm_cell.sv =====
// one slot of the sorted head row
module kwm_cell #(
  parameter bit IS_TOP = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  kwm_pkg::cell_cmd_t  cmd,
  input  logic                pair_here,
  input  logic                pair_above,
  input  kwm_pkg::head_t      above_head,
  input  logic                above_yield,
  input  kwm_pkg::head_t      below_head,
  output kwm_pkg::head_t      head,
  output kwm_pkg::head_t      shown,
  output kwm_pkg::head_t      head_next,
  output logic                yield
);
  import kwm_pkg::*;

  logic fits;

  // stored value not above the broadcast one
  assign fits = (head.value <= cmd.fresh.value);
  // this slot or one above takes the loaded head
  assign yield = above_yield || fits;

  // the top slot shows the new value to its neighbor while an advance starts
  assign shown = (IS_TOP && cmd.advance) ? cmd.fresh : head;

  always_comb begin
    head_next = head;
    if (cmd.load) begin
      if (above_yield) begin
        head_next = above_head;
      end else if (fits) begin
        head_next = cmd.fresh;
      end
    end else if (pair_here) begin
      // upper slot of the compare pair keeps the larger, ties stay put
      head_next = (shown.value < below_head.value) ? below_head : shown;
    end else if (pair_above) begin
      // lower slot of the compare pair takes the smaller
      head_next = (above_head.value < head.value) ? above_head : head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head <= head_next;
    end
  end

endmodule

// ===== rtl/core/k_way_merge_sorted_heads.sv =====
// top level: k-way merge over a row of sorted list heads
// the result of an accepted beat is registered and on the output in the next cycle
// a load does not hold off the next beat; on an advance the sink pass compares one
// neighbor pair per cycle and input is held off until it reaches the bottom
// a stalled result beat also holds off input; reset (synchronous, active high) clears
// every head to value 0, list 0, stops any sink pass and empties the output
module k_way_merge_sorted_heads #(
  parameter int NUM_LISTS = kwm_pkg::NUM_LISTS_DEF
) (
  input logic     clk,
  input logic     rst,
  kwm_in_if.sink  items,
  kwm_out_if.source results
);
  import kwm_pkg::*;

  localparam int POS_W = (NUM_LISTS > 2) ? $clog2(NUM_LISTS - 1) : 1;

  head_t      heads [NUM_LISTS];
  head_t      shown [NUM_LISTS];
  head_t      heads_next [NUM_LISTS];
  logic       yields [NUM_LISTS];
  logic       pairs [NUM_LISTS];
  cell_cmd_t  cmd;
  logic       accept;
  logic       top_live;
  logic       busy;
  logic [POS_W-1:0] wave_pos;

  // output register drains and refills in the same cycle; no beat while the sink pass runs
  assign items.ready = !busy && (!results.valid || results.ready);
  assign accept = items.valid && items.ready;

  // an advance on an exhausted row changes nothing
  assign top_live = (heads[0].value != '0);

  always_comb begin
    cmd.load = accept && (op_t'(items.operation) == OP_LOAD);
    cmd.advance = accept && (op_t'(items.operation) == OP_ADVANCE) && top_live;
    cmd.fresh.value = items.value;
    // a sunk value keeps the list of the head it replaces
    cmd.fresh.list = (op_t'(items.operation) == OP_LOAD) ? items.list_index : heads[0].list;
  end

  // sink pass: the new value replaces the top head, then one compare-and-swap per cycle
  // walks down the row, pair (0,1) in the accept cycle and pair (p,p+1) at wave_pos p
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      wave_pos <= '0;
    end else if (cmd.advance && (NUM_LISTS > 2)) begin
      busy <= 1'b1;
      wave_pos <= POS_W'(1);
    end else if (busy) begin
      if (wave_pos == POS_W'(NUM_LISTS - 2)) begin
        busy <= 1'b0;
      end else begin
        wave_pos <= wave_pos + POS_W'(1);
      end
    end
  end

  // a load lands at the first slot whose head is not above the new one (the yield chain
  // marks that slot and all below) and pushes the rest down one, the last slot falls off;
  // this holds whether or not the row is still in order
  generate
    for (genvar i = 0; i < NUM_LISTS; i++) begin : g_cell
      head_t above_head;
      logic  above_yield;
      logic  pair_above;
      head_t below_head;

      if (i == NUM_LISTS - 1) begin : g_last_pair
        assign pairs[i] = 1'b0;
      end else if (i == 0) begin : g_first_pair
        assign pairs[i] = cmd.advance;
      end else begin : g_mid_pair
        assign pairs[i] = busy && (wave_pos == POS_W'(i));
      end

      if (i == 0) begin : g_top
        assign above_head = '0;
        assign above_yield = 1'b0;
        assign pair_above = 1'b0;
      end else begin : g_mid_above
        assign above_head = shown[i-1];
        assign above_yield = yields[i-1];
        assign pair_above = pairs[i-1];
      end

      if (i == NUM_LISTS - 1) begin : g_bottom
        // nothing below the last slot
        assign below_head = '0;
      end else begin : g_mid_below
        assign below_head = shown[i+1];
      end

      kwm_cell #(
        .IS_TOP (i == 0)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .pair_here   (pairs[i]),
        .pair_above  (pair_above),
        .above_head  (above_head),
        .above_yield (above_yield),
        .below_head  (below_head),
        .head        (heads[i]),
        .shown       (shown[i]),
        .head_next   (heads_next[i]),
        .yield       (yields[i])
      );
    end
  endgenerate

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  // the top slot is final after the first compare, so the result leaves with the accept
  always_ff @(posedge clk) begin
    if (accept) begin
      results.emitted <= cmd.advance;
      results.emitted_value <= cmd.advance ? heads[0].value : '0;
      results.emitted_list <= cmd.advance ? heads[0].list : '0;
      results.next_list <= heads_next[0].list;
      results.finished <= (heads_next[0].value == '0);
    end
  end

endmodule

// ===== bench/tb_k_way_merge_sorted_heads.sv =====
// testbench for the k-way merge head row: directed and random load/advance beats, self-checking
module tb_k_way_merge_sorted_heads;
  timeunit 1ns;
  timeprecision 1ps;
  import kwm_pkg::*;

  localparam int LISTS = NUM_LISTS_DEF;
  localparam int RANDOM_BEATS = 900;
  // cycles with no beat on either side before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // one result beat as the block presents it, field order matches the port concatenation
  typedef struct packed {
    logic               emitted;
    logic [VALUE_W-1:0] value;
    logic [LIST_W-1:0]  list;
    logic [LIST_W-1:0]  next_list;
    logic               finished;
  } merge_result_t;

  // own copy of the head row plus the queue of merge results still owed by the block
  class head_row_scoreboard;
    logic [VALUE_W-1:0] row_value [LISTS];
    logic [LIST_W-1:0]  row_list  [LISTS];
    merge_result_t      merges_due[$];
    int errors;
    int checked;
    int merged;
    int loads;
    int advances;
    int idle_advances;

    function new();
      for (int i = 0; i < LISTS; i++) begin
        row_value[i] = '0;
        row_list[i]  = '0;
      end
    endfunction

    // new head goes ahead of the first head that is equal or smaller, last slot falls off
    function void insert_head(logic [VALUE_W-1:0] v, logic [LIST_W-1:0] l);
      int pos;
      pos = LISTS;
      for (int i = 0; i < LISTS; i++) begin
        if (pos == LISTS && row_value[i] <= v) pos = i;
      end
      if (pos < LISTS) begin
        for (int i = LISTS - 1; i > pos; i--) begin
          row_value[i] = row_value[i-1];
          row_list[i]  = row_list[i-1];
        end
        row_value[pos] = v;
        row_list[pos]  = l;
      end
    endfunction

    // one compare pass: the carried head keeps its place ahead of equal values
    function void sink_top(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] cv, yv;
      logic [LIST_W-1:0]  cl, yl;
      cv = v;
      cl = row_list[0];
      for (int j = 1; j < LISTS; j++) begin
        yv = row_value[j];
        yl = row_list[j];
        if (cv >= yv) begin
          row_value[j-1] = cv;
          row_list[j-1]  = cl;
          cv = yv;
          cl = yl;
        end else begin
          row_value[j-1] = yv;
          row_list[j-1]  = yl;
        end
      end
      row_value[LISTS-1] = cv;
      row_list[LISTS-1]  = cl;
    endfunction

    function void apply_beat(op_t op, logic [LIST_W-1:0] li, logic [VALUE_W-1:0] v);
      merge_result_t r;
      r = '0;
      if (op == OP_LOAD) begin
        loads++;
        insert_head(v, li);
      end else if (row_value[0] != '0) begin
        advances++;
        r.emitted = 1'b1;
        r.value   = row_value[0];
        r.list    = row_list[0];
        sink_top(v);
      end else begin
        idle_advances++;
      end
      r.next_list = row_list[0];
      r.finished  = (row_value[0] == '0);
      merges_due.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] error: %s", $time, msg);
      errors++;
    endtask

    task check_merge(merge_result_t got);
      merge_result_t want;
      checked++;
      if (merges_due.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing expected", checked));
        return;
      end
      want = merges_due.pop_front();
      if (got.emitted !== want.emitted)
        report($sformatf("beat %0d emitted %b, want %b", checked, got.emitted, want.emitted));
      if (got.value !== want.value)
        report($sformatf("beat %0d emitted_value %h, want %h", checked, got.value, want.value));
      if (got.list !== want.list)
        report($sformatf("beat %0d emitted_list %0d, want %0d", checked, got.list, want.list));
      if (got.next_list !== want.next_list)
        report($sformatf("beat %0d next_list %0d, want %0d", checked, got.next_list,
                         want.next_list));
      if (got.finished !== want.finished)
        report($sformatf("beat %0d finished %b, want %b", checked, got.finished, want.finished));
      if (want.emitted) merged++;
    endtask
  endclass

  logic clk;
  logic rst;
  bit   calm;          // both sides run without idling while set
  int   beats_sent;
  int   sessions;
  int   lists_loaded;
  int   quiet_cycles;
  head_row_scoreboard sb;

  kwm_in_if  items();
  kwm_out_if results();

  k_way_merge_sorted_heads #(
    .NUM_LISTS(LISTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: stall with a chance of roughly 27 in a hundred, none during the calm stretch
  always @(negedge clk) begin
    results.ready <= calm || ($urandom_range(0, 99) >= 27);
  end

  // every result beat is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready)
      sb.check_merge({results.emitted, results.emitted_value, results.emitted_list,
                      results.next_list, results.finished});
  end

  // hang detection: no beat on either channel for too long ends the run
  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results still due", quiet_cycles,
               sb.merges_due.size());
      $display("k_way_merge_sorted_heads regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken;
  // valid stays high from one beat to the next unless an idle cycle falls between
  task automatic send_item(input op_t op, input logic [LIST_W-1:0] li,
                           input logic [VALUE_W-1:0] v);
    while (!calm && $urandom_range(0, 99) < 27) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid      <= 1'b1;
    items.operation  <= op;
    items.list_index <= li;
    items.value      <= v;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    sb.apply_beat(op, li, v);
    beats_sent++;
    @(negedge clk);
  endtask

  // hold the sender off until the block owes nothing
  task automatic drain();
    items.valid <= 1'b0;
    @(negedge clk);
    while (sb.merges_due.size() != 0) @(negedge clk);
  endtask

  // narrow values make ties between lists common, wide ones reach the top bit
  function automatic logic [VALUE_W-1:0] draw_value(input bit narrow);
    if (narrow) return VALUE_W'($urandom_range(1, 12));
    case ($urandom_range(0, 5))
      0:       return VALUE_MAX;
      1:       return VALUE_W'($urandom_range(1, 40));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic run_directed();
    // advance on the cleared row is ignored
    send_item(OP_ADVANCE, 3'd7, VALUE_MAX);
    // loads: max value, a zero head, a tie that must land ahead, then fill past the row size
    send_item(OP_LOAD, 3'd7, VALUE_MAX);
    send_item(OP_LOAD, 3'd0, '0);
    send_item(OP_LOAD, 3'd5, VALUE_MAX);
    send_item(OP_LOAD, 3'd6, 31'h4000_0000);
    send_item(OP_LOAD, 3'd1, 31'h2aaa_aaaa);
    send_item(OP_LOAD, 3'd2, 31'h5555_5555);
    send_item(OP_LOAD, 3'd3, 31'h1555_5555);
    // row is full of larger heads, so this one is dropped
    send_item(OP_LOAD, 3'd4, 31'd1);
    // advance with a value equal to the next head: stays on top
    send_item(OP_ADVANCE, 3'd0, VALUE_MAX);
    send_item(OP_ADVANCE, 3'd2, VALUE_MAX);
    // smaller than what was emitted before: each sinks to its place and the row stays in order
    send_item(OP_ADVANCE, 3'd5, 31'h6000_0000);
    send_item(OP_ADVANCE, 3'd3, 31'h7fff_fffe);
    send_item(OP_ADVANCE, 3'd4, 31'h2aaa_aaaa);
    // end-of-list advances until the row runs dry
    repeat (7) send_item(OP_ADVANCE, 3'd1, '0);
    // finished row ignores the advance, then a load restarts it
    send_item(OP_ADVANCE, 3'd6, 31'h5555_5555);
    send_item(OP_LOAD, 3'd4, 31'h0000_0001);
    send_item(OP_ADVANCE, 3'd0, '0);
  endtask

  // a well-formed merge: load each list's first element, then feed whichever list is on top
  task automatic run_session();
    logic [VALUE_W-1:0] elems [8][$];
    int ids[$];
    int k;
    int n;
    int budget;
    bit narrow;
    logic [VALUE_W-1:0] v;
    logic [LIST_W-1:0]  top;
    ids = {0, 1, 2, 3, 4, 5, 6, 7};
    ids.shuffle();
    k = $urandom_range(1, LISTS);
    narrow = ($urandom_range(0, 2) == 0);
    budget = 8;
    for (int i = 0; i < k; i++) begin
      // now and then a list that is empty from the start
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
      for (int e = 0; e < n; e++) elems[ids[i]].push_back(draw_value(narrow));
      elems[ids[i]].rsort();
      elems[ids[i]].push_back('0);
      budget += n + 1;
    end
    for (int i = 0; i < k; i++)
      send_item(OP_LOAD, LIST_W'(ids[i]), elems[ids[i]].pop_front());
    while (sb.row_value[0] != '0 && budget > 0) begin
      budget--;
      top = sb.row_list[0];
      if ($urandom_range(0, 99) < 2) begin
        // stray load in the middle of a merge
        send_item(OP_LOAD, LIST_W'($urandom), draw_value(narrow));
      end else begin
        v = (elems[top].size() != 0) ? elems[top].pop_front() : '0;
        // occasionally a wrong next element breaks the ordering
        if ($urandom_range(0, 99) < 3) v = draw_value(narrow);
        send_item(OP_ADVANCE, LIST_W'($urandom), v);
      end
    end
    sessions++;
    lists_loaded += k;
  endtask

  task automatic run_random();
    int start;
    int done;
    bit pressured;
    start = beats_sent;
    pressured = 1'b0;
    done = 0;
    while (done < RANDOM_BEATS) begin
      calm = (done >= 300 && done < 450);
      if (!pressured && done >= 450) begin
        drain();
        pressured = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        run_session();
      end else begin
        // noise: any operation, any list number, any value including zero
        repeat ($urandom_range(1, 6))
          send_item(op_t'($urandom_range(0, 1)), LIST_W'($urandom),
                    ($urandom_range(0, 4) == 0) ? '0 : draw_value(1'b0));
      end
      done = beats_sent - start;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst              = 1'b1;
    calm             = 1'b0;
    items.valid      = 1'b0;
    items.operation  = 1'b0;
    items.list_index = '0;
    items.value      = '0;
    beats_sent       = 0;
    sessions         = 0;
    lists_loaded     = 0;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    drain();
    run_random();
    drain();
    // catch any stray result beat before the summary
    repeat (4) @(negedge clk);
    $display("covered %0d input beats: %0d loads, %0d advances, %0d advances on a dry row",
             beats_sent, sb.loads, sb.advances, sb.idle_advances);
    $display("%0d merge sessions over %0d lists, %0d results checked, %0d merged values, %0d errors",
             sessions, lists_loaded, sb.checked, sb.merged, sb.errors);
    if (sb.errors == 0 && sb.merges_due.size() == 0) begin
      $display("k_way_merge_sorted_heads regression: pass");
    end else begin
      $display("k_way_merge_sorted_heads regression: fail");
    end
    $finish;
  end

endmodule
